### rtl/dfa_pkg.sv
// Package: shared widths, defaults, status codes, sequencer states and divider structs.
package dfa_pkg;

    localparam int SPOKES_DEF    = 4;
    localparam int TIME_BITS_DEF = 32;
    localparam int NODE_W        = 4;
    localparam int SIZE_W        = 32;
    localparam int TAG_W         = 16;
    localparam int CAP_W         = 32;
    localparam int OUT_TIME_W    = 32;
    localparam int STAT_W        = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1);

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_SKIP = 2'd2,
        STAT_BAD  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               start;
        logic [SIZE_W-1:0]  dividend;
        logic [CAP_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SIZE_W-1:0]  quotient;
    } t_div_rsp;

endpackage

### rtl/dfa_cfg_if.sv
// Interface: configuration write channel carrying the link capacity.
interface dfa_cfg_if import dfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CAP_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dfa_flow_if.sv
// Interface: flow request channel.
interface dfa_flow_if import dfa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [NODE_W-1:0]  src_node;
    logic [NODE_W-1:0]  dst_node;
    logic [SIZE_W-1:0]  data_size;
    logic [SIZE_W-1:0]  deadline;
    logic [SIZE_W-1:0]  window_start;
    logic [TAG_W-1:0]   task_number;
    logic               last_flow;

    modport source (output valid, output src_node, output dst_node, output data_size,
                    output deadline, output window_start, output task_number,
                    output last_flow, input ready);
    modport sink   (input valid, input src_node, input dst_node, input data_size,
                    input deadline, input window_start, input task_number,
                    input last_flow, output ready);
endinterface

### rtl/dfa_result_if.sv
// Interface: admission result channel.
interface dfa_result_if import dfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [TAG_W-1:0]       task_tag;
    logic [OUT_TIME_W-1:0]  sched_start;
    logic [SIZE_W-1:0]      duration;
    logic [STAT_W-1:0]      status;
    logic                   task_end;
    logic                   task_accepted;

    modport source (output valid, output task_tag, output sched_start, output duration,
                    output status, output task_end, output task_accepted, input ready);
    modport sink   (input valid, input task_tag, input sched_start, input duration,
                    input status, input task_end, input task_accepted, output ready);
endinterface

### rtl/dfa_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module dfa_div import dfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int W     = SIZE_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem, n_rem;
    logic [W-1:0]     r_quo, n_quo;
    logic [W-1:0]     r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [W:0] w_shift;
    logic [W:0] w_diff;
    logic       w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = ~w_diff[W];

        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
            n_cnt  = CNT_W'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
            n_quo = {r_quo[W-2:0], w_ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

### rtl/dfa_link_file.sv
// Link free-time store, one entry per directed hub/spoke link.
module dfa_link_file import dfa_pkg::*; #(
    parameter int SPOKES    = SPOKES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [$clog2(2*SPOKES)-1:0]       i_addr,
    input  logic [TIME_BITS-1:0]              i_wr_data,
    output logic [TIME_BITS-1:0]              o_rd_data
);

    localparam int NLINKS = 2 * SPOKES;

    logic [TIME_BITS-1:0] r_free [NLINKS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NLINKS; i++) begin
                r_free[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_free[i_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_free[i_addr];

endmodule

### rtl/deadline_flow_admission_unit.sv
// Top level: deadline-aware flow admission on a hub/spoke star.
//
//   channel   dir  modport               payload
//   i_cfg     in   dfa_cfg_if.sink       data = link capacity
//   i_flow    in   dfa_flow_if.sink      src, dst, size, deadline, window start, task, last
//   o_result  out  dfa_result_if.source  tag, start, duration, status, task end, accepted
//
// A flow on a valid link goes through accept, 32 divider steps plus done,
// sum, decide. A skipped or invalid-link flow goes from accept straight to decide.
// The 32-step radix-2 divider makes up most of that work; one flow is in work at a time.
// Reset clears the link free times, the discard flag and sets capacity to 1.
// The decide step holds while the output register is full and not taken.
module deadline_flow_admission_unit import dfa_pkg::*; #(
    parameter int SPOKES    = SPOKES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dfa_cfg_if.sink        i_cfg,
    dfa_flow_if.sink       i_flow,
    dfa_result_if.source   o_result
);

    localparam int NLINKS = 2 * SPOKES;
    localparam int LINK_W = $clog2(NLINKS);
    localparam int SUM_W  = ((TIME_BITS > SIZE_W) ? TIME_BITS : SIZE_W) + 1;

    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_cap;
    logic                r_disc, n_disc;
    logic [SIZE_W-1:0]   r_ddl, n_ddl;
    logic [SIZE_W-1:0]   r_wst, n_wst;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic                r_last, n_last;
    logic [LINK_W-1:0]   r_idx, n_idx;
    t_status             r_stat, n_stat;
    logic [SIZE_W-1:0]   r_dur, n_dur;
    logic [TIME_BITS-1:0] r_freet, n_freet;
    logic [SUM_W-1:0]    r_lhs, n_lhs;
    logic [SUM_W-1:0]    r_rhs, n_rhs;

    logic                   r_out_valid, n_out_valid;
    logic [TAG_W-1:0]       r_out_tag, n_out_tag;
    logic [OUT_TIME_W-1:0]  r_out_start, n_out_start;
    logic [SIZE_W-1:0]      r_out_dur, n_out_dur;
    t_status                r_out_stat, n_out_stat;
    logic                   r_out_end, n_out_end;
    logic                   r_out_acc, n_out_acc;

    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;
    logic                  w_link_wr;
    logic [TIME_BITS-1:0]  w_link_wdata;
    logic [TIME_BITS-1:0]  w_link_rdata;

    logic                  w_flow_acc;
    logic                  w_to_hub;
    logic                  w_from_hub;
    logic [NODE_W:0]       w_src_m1;
    logic [NODE_W:0]       w_dst_m1;
    logic [NODE_W+1:0]     w_idx_full;
    logic                  w_miss;
    logic                  w_new_disc;
    t_status               w_fin_stat;
    logic [SUM_W-1:0]      w_freet_ext;

    dfa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    dfa_link_file #(
        .SPOKES    (SPOKES),
        .TIME_BITS (TIME_BITS)
    ) u_link_file (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_link_wr),
        .i_addr    (r_idx),
        .i_wr_data (w_link_wdata),
        .o_rd_data (w_link_rdata)
    );

    assign i_cfg.ready  = 1'b1;
    assign i_flow.ready = (r_state == ST_IDLE);
    assign w_flow_acc   = i_flow.valid & i_flow.ready;

    assign w_to_hub   = (i_flow.src_node != '0) && (i_flow.dst_node == '0) &&
                        ({1'b0, i_flow.src_node} <= (NODE_W+1)'(SPOKES));
    assign w_from_hub = (i_flow.src_node == '0) && (i_flow.dst_node != '0) &&
                        ({1'b0, i_flow.dst_node} <= (NODE_W+1)'(SPOKES));
    assign w_src_m1   = {1'b0, i_flow.src_node} - (NODE_W+1)'(1);
    assign w_dst_m1   = {1'b0, i_flow.dst_node} - (NODE_W+1)'(1);
    assign w_idx_full = w_to_hub ? {w_src_m1, 1'b0} : {w_dst_m1, 1'b1};

    assign w_freet_ext = SUM_W'(r_freet);
    assign w_miss      = (r_stat == STAT_OK) && (r_lhs > r_rhs);
    assign w_fin_stat  = w_miss ? STAT_MISS : r_stat;
    assign w_new_disc  = r_disc | (w_fin_stat == STAT_MISS) | (w_fin_stat == STAT_BAD);

    always_comb begin
        n_state     = r_state;
        n_disc      = r_disc;
        n_ddl       = r_ddl;
        n_wst       = r_wst;
        n_tag       = r_tag;
        n_last      = r_last;
        n_idx       = r_idx;
        n_stat      = r_stat;
        n_dur       = r_dur;
        n_freet     = r_freet;
        n_lhs       = r_lhs;
        n_rhs       = r_rhs;
        n_out_valid = r_out_valid & ~o_result.ready;
        n_out_tag   = r_out_tag;
        n_out_start = r_out_start;
        n_out_dur   = r_out_dur;
        n_out_stat  = r_out_stat;
        n_out_end   = r_out_end;
        n_out_acc   = r_out_acc;

        w_div_req.start    = 1'b0;
        w_div_req.dividend = i_flow.data_size;
        w_div_req.divisor  = (r_cap == '0) ? CAP_W'(1) : r_cap;
        w_link_wr          = 1'b0;
        w_link_wdata       = (|r_lhs[SUM_W-1:TIME_BITS]) ? {TIME_BITS{1'b1}}
                                                         : r_lhs[TIME_BITS-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (w_flow_acc) begin
                    n_ddl  = i_flow.deadline;
                    n_wst  = i_flow.window_start;
                    n_tag  = i_flow.task_number;
                    n_last = i_flow.last_flow;
                    n_idx  = w_idx_full[LINK_W-1:0];
                    n_dur  = '0;
                    if (r_disc) begin
                        n_stat  = STAT_SKIP;
                        n_state = ST_DONE;
                    end else if (!(w_to_hub || w_from_hub)) begin
                        n_stat  = STAT_BAD;
                        n_state = ST_DONE;
                    end else begin
                        n_stat          = STAT_OK;
                        w_div_req.start = 1'b1;
                        n_state         = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_dur   = w_div_rsp.quotient;
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_freet = w_link_rdata;
                n_lhs   = SUM_W'(r_dur) + SUM_W'(w_link_rdata);
                n_rhs   = SUM_W'(r_ddl) + SUM_W'(r_wst);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    w_link_wr   = (w_fin_stat == STAT_OK);
                    n_out_valid = 1'b1;
                    n_out_tag   = r_tag;
                    n_out_start = (w_fin_stat == STAT_OK) ? w_freet_ext[OUT_TIME_W-1:0] : '0;
                    n_out_dur   = r_dur;
                    n_out_stat  = w_fin_stat;
                    n_out_end   = r_last;
                    n_out_acc   = r_last & ~w_new_disc;
                    n_disc      = r_last ? 1'b0 : w_new_disc;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_disc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_disc      <= n_disc;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ddl       <= n_ddl;
        r_wst       <= n_wst;
        r_tag       <= n_tag;
        r_last      <= n_last;
        r_idx       <= n_idx;
        r_stat      <= n_stat;
        r_dur       <= n_dur;
        r_freet     <= n_freet;
        r_lhs       <= n_lhs;
        r_rhs       <= n_rhs;
        r_out_tag   <= n_out_tag;
        r_out_start <= n_out_start;
        r_out_dur   <= n_out_dur;
        r_out_stat  <= n_out_stat;
        r_out_end   <= n_out_end;
        r_out_acc   <= n_out_acc;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.task_tag      = r_out_tag;
    assign o_result.sched_start   = r_out_start;
    assign o_result.duration      = r_out_dur;
    assign o_result.status        = r_out_stat;
    assign o_result.task_end      = r_out_end;
    assign o_result.task_accepted = r_out_acc;

endmodule
